>>> rtl/core/inversion_count_sorter_unit_macros.svh
// Assertion macros shared by the sorter RTL.
// Each macro checks on the rising edge of aclk and is disabled while aresetn is low.
`ifndef INVERSION_COUNT_SORTER_UNIT_MACROS_SVH
`define INVERSION_COUNT_SORTER_UNIT_MACROS_SVH

// The property holds at every clock edge.
`define ICS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ICS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ICS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ics_pkg.sv
// Package for the inversion count sorter: widths, state encoding and the
// structs that pass between the sorter cells. No dependencies.
package ics_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned INV_W   = 11;
    localparam logic [INV_W-1:0] INV_MAX = 11'h7FF;

    typedef enum logic [2:0] {
        ST_LOAD   = 3'b001,
        ST_SETTLE = 3'b010,
        ST_DRAIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic                      insert;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic                      gt;
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } cell_link_t;

endpackage

>>> rtl/core/ics_cell.sv
// One cell of the insertion chain: holds one sorted element and its valid bit.
// Depends on ics_pkg for the control and neighbor link structs.
module ics_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  ics_pkg::cell_ctrl_t ctrl,
    input  ics_pkg::cell_link_t lnk_prev,
    input  ics_pkg::cell_link_t lnk_nbr,
    output ics_pkg::cell_link_t lnk_out,
    output logic               at_pos
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [ics_pkg::VALUE_W-1:0] value_reg;
    logic signed [ics_pkg::VALUE_W-1:0] value_next;
    logic                               gt;
    logic                               take;
    logic                               load;

    assign gt     = valid_reg && (value_reg > ctrl.value);
    assign take   = gt || !valid_reg;
    assign load   = ctrl.insert && take && lnk_prev.valid;
    assign at_pos = take && lnk_prev.valid && !lnk_prev.gt;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.pop) begin
            valid_next = lnk_nbr.valid;
            value_next = lnk_nbr.value;
        end else if (load) begin
            valid_next = 1'b1;
            value_next = lnk_prev.gt ? lnk_prev.value : ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign lnk_out = '{gt: gt, valid: valid_reg, value: value_reg};

endmodule

>>> rtl/core/ics_pos_enc.sv
// Encodes the one-hot insertion point reported by the cell chain into an index.
// No dependencies.
module ics_pos_enc #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic [CAPACITY-1:0]         onehot,
    output logic [$clog2(CAPACITY)-1:0] pos
);

    localparam int unsigned IW = $clog2(CAPACITY);

    always_comb begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (onehot[i]) begin
                pos = pos | IW'(i);
            end
        end
    end

endmodule

>>> rtl/core/inversion_count_sorter_unit.sv
// Load phase: one request per cycle; the closing request drops s_tready until the run is out.
// After the closing request is accepted the unit passes through ST_SETTLE, then shows results in ST_DRAIN.
// Drain: one sorted result per cycle while m_tready is high, from the head of the cell chain, CAPACITY at most.
// Synchronous active-low reset clears cell valid bits, counters and the state machine.
// Depends on ics_pkg, ics_cell, ics_pos_enc and inversion_count_sorter_unit_macros.svh.
`include "inversion_count_sorter_unit_macros.svh"

module inversion_count_sorter_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] sorted_value, [42:32] inversions, [47:43] zero
    output logic        m_tuser,   // [0] overflow
    output logic        m_tlast
);

    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned IW    = $clog2(CAPACITY);
    localparam int unsigned SUM_W = ((CW > ics_pkg::INV_W) ? CW : ics_pkg::INV_W) + 1;

    ics_pkg::state_t              state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                greater_reg, greater_next;
    logic                         add_pend_reg, add_pend_next;
    logic [ics_pkg::INV_W-1:0]    total_reg, total_next;
    logic                         dropped_reg, dropped_next;

    ics_pkg::cell_ctrl_t          ctrl;
    ics_pkg::cell_link_t          links     [CAPACITY];
    ics_pkg::cell_link_t          prev_link [CAPACITY];
    ics_pkg::cell_link_t          nbr_link  [CAPACITY];
    logic [CAPACITY-1:0]          at_pos;
    logic [IW-1:0]                pos;

    logic                         in_acc;
    logic                         out_acc;
    logic                         full;
    logic                         ins;
    logic                         run_done;
    logic [SUM_W-1:0]             sum;

    assign s_tready = (state_reg == ics_pkg::ST_LOAD);
    assign in_acc   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign ins      = in_acc && !full;
    assign m_tvalid = (state_reg == ics_pkg::ST_DRAIN);
    assign out_acc  = m_tvalid && m_tready;
    assign m_tlast  = !links[1].valid;
    assign run_done = out_acc && m_tlast;

    assign ctrl = '{insert: ins, pop: out_acc, value: s_tdata};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign prev_link[gi] = '{gt: 1'b0, valid: 1'b1, value: '0};
            end else begin : g_body
                assign prev_link[gi] = links[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_tail
                assign nbr_link[gi] = '{gt: 1'b0, valid: 1'b0, value: '0};
            end else begin : g_inner
                assign nbr_link[gi] = links[gi+1];
            end
            ics_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .lnk_prev (prev_link[gi]),
                .lnk_nbr  (nbr_link[gi]),
                .lnk_out  (links[gi]),
                .at_pos   (at_pos[gi])
            );
        end
    endgenerate

    ics_pos_enc #(
        .CAPACITY (CAPACITY)
    ) u_pos_enc (
        .onehot (at_pos),
        .pos    (pos)
    );

    assign greater_next = count_reg - CW'(pos);
    assign sum          = SUM_W'(total_reg) + SUM_W'(greater_reg);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        add_pend_next = ins;
        total_next    = total_reg;
        dropped_next  = dropped_reg;

        if (ins) begin
            count_next = count_reg + CW'(1);
        end
        if (in_acc && full) begin
            dropped_next = 1'b1;
        end
        if (add_pend_reg) begin
            if (sum > SUM_W'(ics_pkg::INV_MAX)) begin
                total_next = ics_pkg::INV_MAX;
            end else begin
                total_next = sum[ics_pkg::INV_W-1:0];
            end
        end

        unique case (state_reg)
            ics_pkg::ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = ics_pkg::ST_SETTLE;
                end
            end
            ics_pkg::ST_SETTLE: begin
                state_next = ics_pkg::ST_DRAIN;
            end
            ics_pkg::ST_DRAIN: begin
                if (run_done) begin
                    state_next   = ics_pkg::ST_LOAD;
                    count_next   = '0;
                    total_next   = '0;
                    dropped_next = 1'b0;
                end
            end
            default: begin
                state_next = ics_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ics_pkg::ST_LOAD;
            count_reg    <= '0;
            add_pend_reg <= 1'b0;
            total_reg    <= '0;
            dropped_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            add_pend_reg <= add_pend_next;
            total_reg    <= total_next;
            dropped_reg  <= dropped_next;
        end
    end

    always_ff @(posedge aclk) begin
        greater_reg <= greater_next;
    end

    assign m_tdata = {5'b00000, total_reg, links[0].value};
    assign m_tuser = dropped_reg;

    `ICS_ASSERT(a_count_range, count_reg <= CW'(CAPACITY), "Element count exceeds capacity.")
    `ICS_ASSERT_IMPL(a_out_settled, m_tvalid, !add_pend_reg && links[0].valid, "Result shown before the count settled.")
    `ICS_ASSERT_IMPL(a_valid_prefix, links[1].valid, links[0].valid, "Cell chain has a gap at the head.")
    `ICS_ASSERT_NEXT(a_clear_after_run, run_done, count_reg == '0 && !dropped_reg && total_reg == '0, "Run state not cleared after the final result.")

endmodule

>>> test/inversion_count_sorter_unit_tb.sv
// Testbench for inversion_count_sorter_unit: streams sets of signed values in and checks
// every sorted result, its inversion count, overflow flag and end marker against a predictor.
// Depends on ics_pkg and the inversion_count_sorter_unit RTL.
module inversion_count_sorter_unit_tb;

    localparam int unsigned CAPACITY     = 64;
    localparam int unsigned RANDOM_ITEMS = 290;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned IDLE_PERCENT = 9;

    typedef struct packed {
        logic signed [ics_pkg::VALUE_W-1:0] value;
        logic                               last;
    } sort_request_t;

    typedef struct packed {
        logic signed [ics_pkg::VALUE_W-1:0] value;
        logic [ics_pkg::INV_W-1:0]          inversions;
        logic                               overflow;
        logic                               last;
    } sorted_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    sort_request_t                      pending_requests[$];
    sorted_result_t                     expected_results[$];
    logic signed [ics_pkg::VALUE_W-1:0] sorted_store[$];
    logic [ics_pkg::INV_W-1:0]          inversion_tally = '0;
    logic                               dropped_seen = 1'b0;
    int unsigned                        accepted_count = 0;
    int unsigned                        mismatch_count = 0;
    int unsigned                        cycle_count = 0;
    logic                               quiet;

    // A long stretch in the middle of the run runs with neither side idling.
    assign quiet = (accepted_count >= 120) && (accepted_count < 220);

    inversion_count_sorter_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic queue_request(input logic signed [ics_pkg::VALUE_W-1:0] v, input logic l);
        sort_request_t req;
        req.value = v;
        req.last  = l;
        pending_requests.push_back(req);
    endtask

    function automatic logic signed [ics_pkg::VALUE_W-1:0] pick_value(input int unsigned mode);
        logic signed [ics_pkg::VALUE_W-1:0] corners[6];
        corners = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000, 32'shFFFFFFFF,
                    32'sh80000001, 32'sh7FFFFFFE};
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 7)) - 4;
            default: return corners[$urandom_range(0, 5)];
        endcase
    endfunction

    // Inserts one element into the sorted store and, when the set closes,
    // queues the whole sorted set as expected results.
    task automatic insert_and_close(input sort_request_t req);
        int unsigned pos;
        int unsigned greater;
        sorted_result_t res;
        if (sorted_store.size() >= CAPACITY) begin
            dropped_seen = 1'b1;
        end else begin
            pos = 0;
            while (pos < sorted_store.size() && $signed(sorted_store[pos]) <= $signed(req.value))
                pos++;
            greater = sorted_store.size() - pos;
            if (greater > ics_pkg::INV_MAX - inversion_tally)
                inversion_tally = ics_pkg::INV_MAX;
            else
                inversion_tally = inversion_tally + greater[ics_pkg::INV_W-1:0];
            sorted_store.insert(pos, req.value);
        end
        if (req.last) begin
            for (int k = 0; k < sorted_store.size(); k++) begin
                res.value      = sorted_store[k];
                res.inversions = inversion_tally;
                res.overflow   = dropped_seen;
                res.last       = (k == sorted_store.size() - 1);
                expected_results.push_back(res);
            end
            sorted_store.delete();
            inversion_tally = '0;
            dropped_seen    = 1'b0;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                insert_and_close(pending_requests.pop_front());
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0
                        && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_requests[0].value;
                    s_tlast  <= pending_requests[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        sorted_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result value %0d",
                                            $signed(m_tdata[31:0])));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[42:32] !== want.inversions
                            || m_tuser !== want.overflow || m_tlast !== want.last)
                        note_mismatch($sformatf(
                            {"expected value %0d inversions %0d overflow %0b last %0b, ",
                             "got value %0d inversions %0d overflow %0b last %0b"},
                            want.value, want.inversions, want.overflow, want.last,
                            $signed(m_tdata[31:0]), m_tdata[42:32], m_tuser, m_tlast));
                end
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int unsigned generated;
        int unsigned set_index;
        int unsigned set_size;
        int unsigned mode;
        logic signed [ics_pkg::VALUE_W-1:0] v;

        queue_request(32'sh7FFFFFFF, 1'b1);
        queue_request(32'sh80000000, 1'b1);
        queue_request(5, 1'b0);
        queue_request(-3, 1'b0);
        queue_request(5, 1'b0);
        queue_request(32'sh80000000, 1'b0);
        queue_request(32'sh7FFFFFFF, 1'b0);
        queue_request(0, 1'b0);
        queue_request(-1, 1'b0);
        queue_request(-1, 1'b1);
        for (int k = 0; k < 3; k++)
            queue_request(k + 1, k == 2);
        for (int k = 3; k >= 0; k--)
            queue_request(k, k == 0);
        queue_request(32'shAAAAAAAA, 1'b0);
        queue_request(32'sh55555555, 1'b1);

        // The first random sets are a fully reversed store (largest count)
        // and an oversized set; the rest are mostly short.
        generated = 0;
        set_index = 0;
        while (generated < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 2);
            if (set_index == 0)
                set_size = CAPACITY;
            else if (set_index == 1)
                set_size = CAPACITY + 2;
            else if ($urandom_range(0, 19) == 0)
                set_size = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            else
                set_size = $urandom_range(1, 12);
            for (int k = 0; k < set_size; k++) begin
                if (set_index == 0)
                    v = $signed(32'd1000) - $signed(k * 3) + $signed($urandom_range(0, 2));
                else
                    v = pick_value(mode);
                queue_request(v, k == set_size - 1);
            end
            generated += set_size;
            set_index++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_results.size() > 0)
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
